// File: rtl/ioct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioct_pkg: types and codes of the in-order commit tracker
// Transfer structs for both channels and status codes.
// ----------------------------------------------------------------------------
package ioct_pkg;

	localparam logic FUNC_ALLOC  = 1'b0;
	localparam logic FUNC_COMMIT = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	typedef struct packed {
		logic        func;
		logic [31:0] obj_num;
		logic [31:0] tag_id;
		logic [31:0] entry_id;
		logic [31:0] done_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] new_commit_id;
		logic        updated;
		logic [31:0] position_object;
		logic [31:0] position_tag;
		logic [31:0] position_entry;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] tag;
		logic [31:0] entry;
	} pos_t;

endpackage

// File: rtl/ioct_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioct_ring: pending commit memory
// One write port, one registered read port; holds object, tag and entry.
// ----------------------------------------------------------------------------
module ioct_ring import ioct_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [95:0]              wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [95:0]              rdata
);

	logic [95:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/in_order_commit_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_order_commit_tracker: in-order commit retirement with position list
// Flow: allocate and failed commit pass EXEC, then ONE answers them.
// Commit: EXEC marks the entry done, RD and HOLD retire done entries in
// order, then EMIT sends one list slot per cycle unless out_stall holds it.
// Throughput: one item in flight; a transfer is taken only when idle.
// Reset: ids restart at 1, done flags and position list clear at once.
// ----------------------------------------------------------------------------
module in_order_commit_tracker import ioct_pkg::*; #(
	parameter int PENDING_DEPTH  = 16,
	parameter int POSITION_SLOTS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int AW = $clog2(PENDING_DEPTH);
	localparam int RING = 1 << AW;
	localparam int CW = $clog2(POSITION_SLOTS + 1);
	localparam int SW = (POSITION_SLOTS > 1) ? $clog2(POSITION_SLOTS) : 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_RD   = 6'b000100,
		S_HOLD = 6'b001000,
		S_EMIT = 6'b010000,
		S_ONE  = 6'b100000
	} state_t;

	state_t      state_q;
	in_item_t    item_q;
	logic [31:0] last_id_q, oldest_id_q, held_obj_q;
	logic [AW-1:0] head_q;
	logic [RING-1:0] done_q;
	pos_t        held_q [POSITION_SLOTS];
	logic [CW-1:0] count_q;
	logic [SW-1:0] idx_q;
	logic        retired_q;
	logic [1:0]  res_status_q;
	logic [31:0] res_id_q;

	logic        ring_we;
	logic [AW-1:0] ring_waddr;
	logic [95:0] ring_rdata;

	logic [31:0] pcount, offset, tag_r;
	logic [AW-1:0] tail;
	logic        hit0;
	logic [SW-1:0] hit_idx;
	logic        hit_any;

	assign pcount = last_id_q - oldest_id_q + 32'd1;
	assign offset = item_q.done_id - oldest_id_q;
	assign tail   = head_q + pcount[AW-1:0];
	assign ring_we = (state_q == S_EXEC) && (item_q.func == FUNC_ALLOC)
		&& (pcount < 32'(PENDING_DEPTH));
	assign ring_waddr = tail;
	assign tag_r = ring_rdata[63:32];

	ioct_ring #(.DEPTH(RING)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata ({item_q.obj_num, item_q.tag_id, item_q.entry_id}),
		.raddr (head_q),
		.rdata (ring_rdata)
	);

	always_comb begin
		hit0 = (count_q != '0) && (held_q[0].tag == tag_r);
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = POSITION_SLOTS - 1; i >= 1; i--) begin
			if (CW'(i) < count_q && held_q[i].tag == tag_r) begin
				hit_any = 1'b1;
				hit_idx = SW'(i);
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_id_q   <= '0;
			oldest_id_q <= 32'd1;
			head_q      <= '0;
			done_q      <= '0;
			held_obj_q  <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			retired_q   <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					retired_q <= 1'b0;
					if (item_q.func == FUNC_ALLOC) begin
						if (pcount >= 32'(PENDING_DEPTH)) begin
							res_status_q <= ST_FULL;
							res_id_q     <= '0;
						end else begin
							res_status_q <= ST_OK;
							done_q[tail] <= 1'b0;
							last_id_q    <= last_id_q + 32'd1;
							res_id_q     <= last_id_q + 32'd1;
						end
						state_q <= S_ONE;
					end else if (offset >= pcount
						|| pcount > 32'(PENDING_DEPTH)) begin
						res_status_q <= ST_UNKNOWN;
						res_id_q     <= '0;
						state_q <= S_ONE;
					end else begin
						res_status_q <= ST_OK;
						res_id_q     <= '0;
						done_q[head_q + offset[AW-1:0]] <= 1'b1;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (pcount != '0 && done_q[head_q]) begin
						state_q <= S_HOLD;
					end else if (retired_q && count_q != '0) begin
						idx_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_ONE;
					end
				end
				S_HOLD: begin
					held_obj_q <= ring_rdata[95:64];
					if (hit0) begin
						held_q[0].entry <= ring_rdata[31:0];
					end else begin
						for (int i = POSITION_SLOTS - 1; i >= 1; i--) begin
							if ((hit_any && SW'(i) <= hit_idx) ||
								(!hit_any && CW'(i) <= count_q)) begin
								held_q[i] <= held_q[i-1];
							end
						end
						held_q[0] <= '{tag: tag_r, entry: ring_rdata[31:0]};
						if (!hit_any && count_q < CW'(POSITION_SLOTS)) begin
							count_q <= count_q + CW'(1);
						end
					end
					done_q[head_q] <= 1'b0;
					head_q      <= head_q + AW'(1);
					oldest_id_q <= oldest_id_q + 32'd1;
					retired_q   <= 1'b1;
					state_q     <= S_RD;
				end
				S_EMIT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						out_data  <= '{status: ST_OK, new_commit_id: '0, updated: 1'b1,
							position_object: held_obj_q, position_tag: held_q[idx_q].tag,
							position_entry: held_q[idx_q].entry,
							last: (CW'(idx_q) + CW'(1) == count_q)};
						if (CW'(idx_q) + CW'(1) == count_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + SW'(1);
						end
					end
				end
				S_ONE: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						out_data  <= '{status: res_status_q, new_commit_id: res_id_q,
							updated: 1'b0, position_object: '0, position_tag: '0,
							position_entry: '0, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (out_valid && !out_stall
				&& !((state_q == S_EMIT) || (state_q == S_ONE))) begin
				out_valid <= 1'b0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(POSITION_SLOTS)) else $error("position list overflow");
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcount <= 32'(PENDING_DEPTH)) else $error("pending ring overflow");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("input taken while busy");

endmodule
